[hw/rtl/dmdc_pkg.sv]
package dmdc_pkg;

   // Default sizing of the block.
   localparam int MAX_POINTS_DEF = 64;
   localparam int DIST_BITS_DEF  = 8;

   // Item kinds carried in req_tuser.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_UPD,
      ST_LOAD_COL,
      ST_QRY_SUM,
      ST_QRY_OUT
   } state_type;

endpackage

[hw/rtl/dmdc_ram.sv]
module dmdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/distance_matrix_double_centering.sv]
// Double centering for classical multidimensional scaling. A load item (req_tuser = 0)
// stores the square of one upper-triangle distance (row < col < n) and updates the two
// row sums and the grand total; loads on or below the diagonal, or outside n, are dropped
// without a result. A query item (req_tuser = 1) returns 2*n*n times the centered Gram
// entry as an exact signed integer, or index_error with a zero value when an index is not
// below n. The squares live in one single-port-write RAM of 2**(2*clog2(MAX_POINTS))
// entries (4096 at the default size) and the row sums in two mirrored RAMs, so both row
// sums can be read in the same cycle. A valid load is accepted, writes its square and row
// i, then row j; a dropped load is only accepted; a query is accepted, does the first
// multiply, then the second into the result register, waiting while the output is full;
// an out-of-range query skips the first multiply. The single write port of the row-sum
// RAMs and the two dependent multiplies set these steps. After reset the block zeroes its
// RAMs, one entry per cycle, while req_tready stays low; csr writes are taken at any time.
module distance_matrix_double_centering #(
   parameter int MAX_POINTS = dmdc_pkg::MAX_POINTS_DEF,
   parameter int DIST_BITS  = dmdc_pkg::DIST_BITS_DEF,
   localparam int IDX_BITS  = $clog2(MAX_POINTS),
   localparam int CFG_BITS  = $clog2(MAX_POINTS + 1),
   localparam int SQ_BITS   = 2 * DIST_BITS,
   localparam int TOT_BITS  = SQ_BITS + 2 * IDX_BITS + 1,
   localparam int OUT_BITS  = TOT_BITS + 1,
   localparam int REQ_BITS  = ((2 * IDX_BITS + DIST_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((OUT_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // Configuration write: points_in_use.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_BITS-1:0] csr_wdata,
   // Input items.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // row_index, col_index, distance, zero fill
   input  logic                req_tuser,  // opcode
   // Result items.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,  // centred_scaled, zero fill
   output logic                rsp_tuser   // index_error
);

   import dmdc_pkg::*;

   localparam int NB       = IDX_BITS + 1;
   localparam int ROW_BITS = SQ_BITS + IDX_BITS + 1;
   localparam int T_BITS   = SQ_BITS + IDX_BITS + 3;
   localparam int P_BITS   = NB + 1 + T_BITS;
   localparam int SQA_BITS = 2 * IDX_BITS;

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0] cfg_ff, cfg_in;
   logic [NB-1:0]       n_eff;

   logic [IDX_BITS-1:0]  req_row, req_col, req_lo, req_hi;
   logic [DIST_BITS-1:0] req_dist;
   logic                 req_fire, ld_ok, q_err;

   logic [IDX_BITS-1:0] row_ff, row_in, col_ff, col_in;
   logic                diag_ff, diag_in, err_ff, err_in;
   logic [SQ_BITS-1:0]  newsq_ff, newsq_in;
   logic [ROW_BITS-1:0] rsj_ff, rsj_in;
   logic [TOT_BITS-1:0] tot_ff, tot_in;
   logic signed [T_BITS-1:0] t_ff, t_in;
   logic [SQA_BITS-1:0] clr_ff, clr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                sq_we, rs_we, rsp_load, out_free;
   logic [SQA_BITS-1:0] sq_wr_addr;
   logic [SQ_BITS-1:0]  sq_wr_data, sq_rd_data, sq_old;
   logic [IDX_BITS-1:0] rs_wr_addr;
   logic [ROW_BITS-1:0] rs_wr_data, rs_a_rd, rs_b_rd, rsi_new, rsj_new;
   logic [TOT_BITS-1:0] tot_new;
   logic [NB+SQ_BITS-1:0]    nsq;
   logic signed [P_BITS-1:0] prod, v_full;

   // Effective point count: zero acts as one, large values clamp to the maximum.
   always_comb begin
      if (cfg_ff == '0) begin
         n_eff = NB'(1);
      end else if (cfg_ff > CFG_BITS'(MAX_POINTS)) begin
         n_eff = NB'(MAX_POINTS);
      end else begin
         n_eff = NB'(cfg_ff);
      end
   end

   assign csr_ready = 1'b1;
   assign cfg_in    = (csr_valid && csr_ready) ? csr_wdata : cfg_ff;

   // Input field decode.
   assign req_row  = req_tdata[IDX_BITS-1:0];
   assign req_col  = req_tdata[2*IDX_BITS-1:IDX_BITS];
   assign req_dist = req_tdata[2*IDX_BITS+DIST_BITS-1:2*IDX_BITS];
   assign req_fire = req_tvalid && req_tready;
   assign req_lo   = (req_row < req_col) ? req_row : req_col;
   assign req_hi   = (req_row < req_col) ? req_col : req_row;
   assign ld_ok    = (req_row < req_col) && ({1'b0, req_col} < n_eff);
   assign q_err    = ({1'b0, req_row} >= n_eff) || ({1'b0, req_col} >= n_eff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_QUERY) begin
                  state_in = q_err ? ST_QRY_OUT : ST_QRY_SUM;
               end else if (ld_ok) begin
                  state_in = ST_LOAD_UPD;
               end
            end
         end
         ST_LOAD_UPD: state_in = ST_LOAD_COL;
         ST_LOAD_COL: state_in = ST_IDLE;
         ST_QRY_SUM:  state_in = ST_QRY_OUT;
         ST_QRY_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and RAM write controls.
   always_comb begin
      req_tready = 1'b0;
      sq_we      = 1'b0;
      sq_wr_addr = {row_ff, col_ff};
      sq_wr_data = newsq_ff;
      rs_we      = 1'b0;
      rs_wr_addr = row_ff;
      rs_wr_data = rsi_new;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            sq_we      = 1'b1;
            sq_wr_addr = clr_ff;
            sq_wr_data = '0;
            rs_we      = 1'b1;
            rs_wr_addr = clr_ff[IDX_BITS-1:0];
            rs_wr_data = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_LOAD_UPD: begin
            sq_we = 1'b1;
            rs_we = 1'b1;
         end
         ST_LOAD_COL: begin
            rs_we      = 1'b1;
            rs_wr_addr = col_ff;
            rs_wr_data = rsj_ff;
         end
         ST_QRY_OUT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Squared distances, addressed by the ordered pair (low index, high index).
   dmdc_ram #(
      .WIDTH(SQ_BITS),
      .DEPTH(1 << SQA_BITS)
   ) u_sq_ram (
      .clock  (clock),
      .wr_en  (sq_we),
      .wr_addr(sq_wr_addr),
      .wr_data(sq_wr_data),
      .rd_addr({req_lo, req_hi}),
      .rd_data(sq_rd_data)
   );

   // Row sums, mirrored so that rows i and j are read in the same cycle.
   dmdc_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(1 << IDX_BITS)
   ) u_rs_a_ram (
      .clock  (clock),
      .wr_en  (rs_we),
      .wr_addr(rs_wr_addr),
      .wr_data(rs_wr_data),
      .rd_addr(req_row),
      .rd_data(rs_a_rd)
   );

   dmdc_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(1 << IDX_BITS)
   ) u_rs_b_ram (
      .clock  (clock),
      .wr_en  (rs_we),
      .wr_addr(rs_wr_addr),
      .wr_data(rs_wr_data),
      .rd_addr(req_col),
      .rd_data(rs_b_rd)
   );

   // Load update: replace the old square in both row sums and the grand total.
   assign sq_old  = diag_ff ? '0 : sq_rd_data;
   assign rsi_new = rs_a_rd - ROW_BITS'(sq_old) + ROW_BITS'(newsq_ff);
   assign rsj_new = rs_b_rd - ROW_BITS'(sq_old) + ROW_BITS'(newsq_ff);
   assign tot_new = tot_ff - (TOT_BITS'(sq_old) << 1) + (TOT_BITS'(newsq_ff) << 1);

   // Query: first t = rs_i + rs_j - n*D2, then n*t - total.
   assign nsq    = n_eff * sq_old;
   assign prod   = $signed({1'b0, n_eff}) * t_ff;
   assign v_full = prod - $signed(P_BITS'(tot_ff));

   // Next values of the item and datapath registers.
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      diag_in      = diag_ff;
      err_in       = err_ff;
      newsq_in     = newsq_ff;
      rsj_in       = rsj_ff;
      tot_in       = tot_ff;
      t_in         = t_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + SQA_BITS'(1);
      end
      if (req_fire) begin
         row_in   = req_row;
         col_in   = req_col;
         diag_in  = (req_row == req_col);
         err_in   = q_err;
         newsq_in = SQ_BITS'(req_dist) * SQ_BITS'(req_dist);
      end
      if (state_ff == ST_LOAD_UPD) begin
         rsj_in = rsj_new;
         tot_in = tot_new;
      end
      if (state_ff == ST_QRY_SUM) begin
         t_in = T_BITS'(rs_a_rd) + T_BITS'(rs_b_rd) - T_BITS'(nsq);
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = err_ff;
         rsp_data_in  = err_ff ? '0 : v_full[OUT_BITS-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cfg_ff       <= CFG_BITS'(MAX_POINTS);
         clr_ff       <= '0;
         tot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         clr_ff       <= clr_in;
         tot_ff       <= tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      diag_ff     <= diag_in;
      err_ff      <= err_in;
      newsq_ff    <= newsq_in;
      rsj_ff      <= rsj_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_data_ff);
   assign rsp_tuser  = rsp_err_ff;

   // A result only appears after the output step of a query.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QRY_OUT))
      else $error("result raised outside the query output step");

   // An index error always carries a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_data_ff == '0))
      else $error("index error with nonzero value");

   // The row-i update is always followed by the row-j update of the same item.
   a_load_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD_UPD) |=> (state_ff == ST_LOAD_COL) && $stable(col_ff))
      else $error("row-j update missing after row-i update");

   // A finished query waits while the output register is still full.
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_QRY_OUT))
      else $error("query result dropped while output stalled");

endmodule
